[hw/rtl/cpcf_pkg.sv]
// cpcf_pkg: shared types and constants of the channel pair coincidence finder
// no dependencies
package cpcf_pkg;

    localparam int TIME_W     = 63;
    localparam int CH_W       = 8;
    localparam int PL_W       = 64;
    localparam int PH_W       = 40;
    localparam int WIN_W      = 20;
    localparam int WIN_SHIFT  = 10;
    localparam int SPAN_W     = WIN_W + WIN_SHIFT;
    localparam int PAIR_IDX_W = 7;
    localparam int PAIR_SLOTS = 128;
    localparam logic [CH_W-1:0] IGNORE_MASK = 8'h0E;
    localparam logic [WIN_W-1:0] WIN_RESET  = 20'd1;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [CH_W-1:0]   channel;
        logic [PL_W-1:0]   pl;
        logic [PH_W-1:0]   ph;
    } entry_t;

    typedef struct packed {
        logic mark;
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[hw/rtl/cpcf_if.sv]
// cpcf_if: event and pair channel interfaces with valid/ready handshake
// depends on nothing but its parameter
interface cpcf_event_if;
    logic        valid;
    logic        ready;
    logic [62:0] event_time;
    logic [7:0]  event_channel;
    logic [63:0] payload_low;
    logic [39:0] payload_high;
    modport source (output valid, event_time, event_channel, payload_low, payload_high,
                    input ready);
    modport sink (input valid, event_time, event_channel, payload_low, payload_high,
                  output ready);
endinterface

interface cpcf_pair_if #(parameter int COUNT_WIDTH = 48);
    logic                   valid;
    logic                   ready;
    logic [62:0]            first_time;
    logic [7:0]             first_channel;
    logic [63:0]            first_payload_low;
    logic [39:0]            first_payload_high;
    logic [62:0]            second_time;
    logic [7:0]             second_channel;
    logic [63:0]            second_payload_low;
    logic [39:0]            second_payload_high;
    logic [COUNT_WIDTH-1:0] pair_total;
    logic                   overflow_seen;
    logic                   last_of_run;
    modport source (output valid, first_time, first_channel, first_payload_low,
                    first_payload_high, second_time, second_channel, second_payload_low,
                    second_payload_high, pair_total, overflow_seen, last_of_run,
                    input ready);
    modport sink (input valid, first_time, first_channel, first_payload_low,
                  first_payload_high, second_time, second_channel, second_payload_low,
                  second_payload_high, pair_total, overflow_seen, last_of_run,
                  output ready);
endinterface

[hw/rtl/channel_pair_coincidence_finder.sv]
// channel_pair_coincidence_finder: top level, row of waiting cells and sequencer
// depends on cpcf_pkg, cpcf_if, cpcf_cell, cpcf_count_mem
//
// usage: time-sorted detector words enter on events, pair words leave on pairs,
// both valid/ready. cfg_we with cfg_wdata sets the window in units of 1024
// ticks; write it only while the block is idle.
// an event goes through these steps: accept, flag all cells in parallel,
// remove each waiting entry that it expires or matches from the cell row,
// one per step (matches in arrival order), one step that finds nothing left
// to remove, then append and store the pair counter.
// a pair word appears in the cycle after its removal and sits in the output
// register; a stalled receiver holds the sequencer only when a further pair
// is ready to go. reset empties the row, clears all pair counters and the
// overflow flag and sets the window to 1. a full row drops the new event and
// sets overflow_seen for good.
module channel_pair_coincidence_finder #(
    parameter int PENDING_DEPTH = 32,
    parameter int COUNT_WIDTH   = 48
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cpcf_pkg::WIN_W-1:0]       cfg_wdata,
    cpcf_event_if.sink                       events,
    cpcf_pair_if.source                      pairs
);

    localparam int IDX_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int FILL_W = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MARK, ST_SCAN, ST_APPEND} state_t;

    state_t                       state_reg;
    cpcf_pkg::entry_t             cur_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [cpcf_pkg::WIN_W-1:0]   win_reg;
    logic                         overflow_reg;
    logic [COUNT_WIDTH-1:0]       count_reg;
    logic                         out_valid_reg;
    cpcf_pkg::entry_t             out_first_reg;
    cpcf_pkg::entry_t             out_second_reg;
    logic [COUNT_WIDTH-1:0]       out_total_reg;
    logic                         out_ovf_reg;
    logic                         out_last_reg;

    cpcf_pkg::entry_t             ent   [PENDING_DEPTH];
    logic                         kill  [PENDING_DEPTH];
    logic                         hit   [PENDING_DEPTH];
    cpcf_pkg::cell_ctrl_t         ctrl  [PENDING_DEPTH];

    logic [cpcf_pkg::SPAN_W-1:0]  span;
    logic                         ignored;
    logic                         any_doomed;
    logic [IDX_W-1:0]             sel;
    logic                         sel_hit;
    logic                         more_hit;
    logic                         can_emit;
    logic                         remove;
    logic                         full;
    logic [COUNT_WIDTH-1:0]       mem_rd;
    logic [COUNT_WIDTH-1:0]       count_inc;
    cpcf_pkg::entry_t             in_ent;

    assign span    = {win_reg, {cpcf_pkg::WIN_SHIFT{1'b0}}};
    assign ignored = (cur_reg.channel & cpcf_pkg::IGNORE_MASK) == cpcf_pkg::IGNORE_MASK;
    assign full    = fill_reg == FILL_W'(PENDING_DEPTH);
    assign count_inc = count_reg + COUNT_WIDTH'(1);
    assign can_emit  = !out_valid_reg || pairs.ready;

    assign in_ent.stamp   = events.event_time;
    assign in_ent.channel = events.event_channel;
    assign in_ent.pl      = events.payload_low;
    assign in_ent.ph      = events.payload_high;

    // oldest entry to remove, and whether a later match follows it
    always_comb
    begin
        any_doomed = 1'b0;
        sel        = '0;
        more_hit   = 1'b0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--)
        begin
            if (kill[i] || hit[i])
            begin
                any_doomed = 1'b1;
                sel        = IDX_W'(i);
            end
        end
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            if (hit[i] && (IDX_W'(i) > sel))
                more_hit = 1'b1;
        end
        sel_hit = hit[sel];
    end

    assign remove = (state_reg == ST_SCAN) && any_doomed && (!sel_hit || can_emit);

    always_comb
    begin
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            ctrl[i].mark  = state_reg == ST_MARK;
            ctrl[i].shift = remove && (IDX_W'(i) >= sel);
            ctrl[i].load  = (state_reg == ST_APPEND) && !ignored && !full
                            && (FILL_W'(i) == fill_reg);
        end
    end

    for (genvar g = 0; g < PENDING_DEPTH; g++)
    begin : g_cell
        cpcf_pkg::entry_t nbr_ent;
        logic             nbr_kill;
        logic             nbr_hit;

        if (g < PENDING_DEPTH - 1)
        begin : g_mid
            assign nbr_ent  = ent[g+1];
            assign nbr_kill = kill[g+1];
            assign nbr_hit  = hit[g+1];
        end
        else
        begin : g_end
            assign nbr_ent  = '0;
            assign nbr_kill = 1'b0;
            assign nbr_hit  = 1'b0;
        end

        cpcf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[g]),
            .live     (FILL_W'(g) < fill_reg),
            .cur      (cur_reg),
            .span     (span),
            .ignored  (ignored),
            .nbr_ent  (nbr_ent),
            .nbr_kill (nbr_kill),
            .nbr_hit  (nbr_hit),
            .ent      (ent[g]),
            .kill     (kill[g]),
            .hit      (hit[g])
        );
    end

    cpcf_count_mem #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (events.event_channel[7:1]),
        .rd_data (mem_rd),
        .wr_en   (state_reg == ST_APPEND),
        .wr_addr (cur_reg.channel[7:1]),
        .wr_data (count_reg)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && events.valid)
            cur_reg <= in_ent;
        if (state_reg == ST_MARK)
            count_reg <= mem_rd;
        else if (remove && sel_hit)
            count_reg <= count_inc;
        if (remove && sel_hit)
        begin
            out_first_reg  <= ent[sel];
            out_second_reg <= cur_reg;
            out_total_reg  <= count_inc;
            out_ovf_reg    <= overflow_reg;
            out_last_reg   <= !more_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            win_reg       <= cpcf_pkg::WIN_RESET;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                win_reg <= cfg_wdata;
            if (pairs.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (events.valid)
                        state_reg <= ST_MARK;
                end
                ST_MARK:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (!any_doomed)
                        state_reg <= ST_APPEND;
                    else if (remove)
                    begin
                        fill_reg <= fill_reg - FILL_W'(1);
                        if (sel_hit)
                            out_valid_reg <= 1'b1;
                    end
                end
                ST_APPEND:
                begin
                    if (!ignored)
                    begin
                        if (full)
                            overflow_reg <= 1'b1;
                        else
                            fill_reg <= fill_reg + FILL_W'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign events.ready = state_reg == ST_IDLE;

    assign pairs.valid               = out_valid_reg;
    assign pairs.first_time          = out_first_reg.stamp;
    assign pairs.first_channel       = out_first_reg.channel;
    assign pairs.first_payload_low   = out_first_reg.pl;
    assign pairs.first_payload_high  = out_first_reg.ph;
    assign pairs.second_time         = out_second_reg.stamp;
    assign pairs.second_channel      = out_second_reg.channel;
    assign pairs.second_payload_low  = out_second_reg.pl;
    assign pairs.second_payload_high = out_second_reg.ph;
    assign pairs.pair_total          = out_total_reg;
    assign pairs.overflow_seen       = out_ovf_reg;
    assign pairs.last_of_run         = out_last_reg;

endmodule

[hw/rtl/cpcf_cell.sv]
// cpcf_cell: one waiting-event slot with expiry and partner match flags
// depends on cpcf_pkg
module cpcf_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpcf_pkg::cell_ctrl_t          ctrl,
    input  logic                          live,
    input  cpcf_pkg::entry_t              cur,
    input  logic [cpcf_pkg::SPAN_W-1:0]   span,
    input  logic                          ignored,
    input  cpcf_pkg::entry_t              nbr_ent,
    input  logic                          nbr_kill,
    input  logic                          nbr_hit,
    output cpcf_pkg::entry_t              ent,
    output logic                          kill,
    output logic                          hit
);

    cpcf_pkg::entry_t ent_reg;
    logic             kill_reg;
    logic             hit_reg;
    logic [63:0]      limit;
    logic             expired;

    assign limit   = {1'b0, ent_reg.stamp} + 64'(span);
    assign expired = live && ({1'b0, cur.stamp} > limit);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            ent_reg <= cur;
        else if (ctrl.shift)
            ent_reg <= nbr_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (ctrl.mark)
        begin
            kill_reg <= expired;
            hit_reg  <= live && !expired && !ignored
                        && (ent_reg.channel == (cur.channel ^ 8'h01));
        end
        else if (ctrl.shift)
        begin
            kill_reg <= nbr_kill;
            hit_reg  <= nbr_hit;
        end
    end

    assign ent  = ent_reg;
    assign kill = kill_reg;
    assign hit  = hit_reg;

endmodule

[hw/rtl/cpcf_count_mem.sv]
// cpcf_count_mem: per-pair counters, one write and one registered read port
// depends on cpcf_pkg
module cpcf_count_mem #(
    parameter int COUNT_WIDTH = 48
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cpcf_pkg::PAIR_IDX_W-1:0]   rd_addr,
    output logic [COUNT_WIDTH-1:0]            rd_data,
    input  logic                              wr_en,
    input  logic [cpcf_pkg::PAIR_IDX_W-1:0]   wr_addr,
    input  logic [COUNT_WIDTH-1:0]            wr_data
);

    logic [COUNT_WIDTH-1:0]          mem [cpcf_pkg::PAIR_SLOTS];
    logic [cpcf_pkg::PAIR_SLOTS-1:0] vld_reg;
    logic [COUNT_WIDTH-1:0]          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    logic rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
